// ===== hdl/ypvt_pkg.sv =====
`default_nettype none

package ypvt_pkg;

  // Stream word widths.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;

  // Field widths.
  localparam int DELTA_W = 16;
  localparam int SENS_W  = 16;
  localparam int LIMIT_W = 14;
  localparam int YAW_W   = 16;
  localparam int PITCH_W = 15;
  localparam int DIR_W   = 16;
  localparam int TAB_W   = 15;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_SENSITIVITY = 1'b0;
  localparam logic REG_MAX_PITCH   = 1'b1;
  localparam logic [SENS_W-1:0]  SENS_RESET  = 16'd256;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd16000;

  // Output queue that absorbs the words still in the pipeline.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int CREDIT_W   = 4;

  // Quarter turn in Q2.30.
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Floor quotient of two non-negative values by long division. It only runs
  // while the sine table is elaborated, so it builds no logic.
  function automatic longint div_floor(input longint num, input longint den);
    longint quo;
    longint rem;
    int     b;
    quo = 0;
    rem = 0;
    for (b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (64'sd1 <<< b);
      end
    end
    return quo;
  endfunction

  // One quarter-wave sine entry, round(32767 * sin(idx * pi/2 / 2^tab_bits)),
  // evaluated with a fixed-point Taylor series to fifteenth order.
  function automatic logic [TAB_W-1:0] sine_entry(input longint idx, input int tab_bits);
    longint x;
    longint t;
    longint sum;
    longint q;
    int     k;
    x   = (HALF_PI_Q30 * idx) >>> tab_bits;
    t   = x;
    sum = x;
    for (k = 1; k <= 7; k++) begin
      t = (t * x) >>> 30;
      t = (t * x) >>> 30;
      t = div_floor(t, longint'((2 * k) * (2 * k + 1)));
      if (k[0]) begin
        sum = sum - t;
      end else begin
        sum = sum + t;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
    if (q > 32767) begin
      q = 32767;
    end
    return q[TAB_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/yaw_pitch_view_tracker.sv =====
// Stages: input register, scaling, accumulators, table read, direction products, queue.
// Throughput: one word per cycle while s_axis_tready is high; the eight-word output queue
// with credit counting lowers it once eight words are in the pipeline and queue together.
// Reset (synchronous, active high): empties the pipeline and queue, clears yaw and pitch
// to zero, and loads sensitivity 256 and max_pitch 16000.
`default_nettype none

module yaw_pitch_view_tracker #(
  parameter int ANGLE_BITS      = 16,
  parameter int FRACTION_BITS   = 8,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire                                clk,
  input  wire                                rst,
  // Input stream. tdata: delta_x [15:0], delta_y [31:16]. tuser: delta_bad [0].
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [ypvt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  wire                                s_axis_tuser,
  // Output stream. tdata: yaw_angle [15:0], pitch_angle [30:16], dir_x [46:31],
  // dir_y [62:47], dir_z [78:63], zero [79].
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [ypvt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Configuration port.
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [ypvt_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire  [ypvt_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ypvt_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import ypvt_pkg::*;

  localparam int ACC_BITS   = ANGLE_BITS + FRACTION_BITS;
  localparam int PROD_W     = DELTA_W + SENS_W + 1;
  localparam int YEXT_W     = (ACC_BITS > PROD_W) ? ACC_BITS : PROD_W;
  localparam int PACC_W     = PITCH_W + FRACTION_BITS;
  localparam int PSUM_W     = ((PACC_W > PROD_W) ? PACC_W : PROD_W) + 1;
  localparam int PHASE_BITS = SINE_TABLE_BITS + 2;
  localparam int TAB_N      = 1 << SINE_TABLE_BITS;
  localparam int ADDR_W     = SINE_TABLE_BITS + 1;

  // Configuration registers.
  logic [SENS_W-1:0]  sensitivity;
  logic [LIMIT_W-1:0] max_pitch;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity <= SENS_RESET;
      max_pitch   <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_SENSITIVITY: sensitivity <= pwdata[SENS_W-1:0];
        REG_MAX_PITCH:   max_pitch   <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SENSITIVITY: prdata = APB_DATA_W'(sensitivity);
      REG_MAX_PITCH:   prdata = APB_DATA_W'(max_pitch);
      default:         prdata = '0;
    endcase
  end

  // Credit count covers words in the pipeline plus words in the queue.
  logic [CREDIT_W-1:0] credit_used;
  logic                in_take;
  logic                out_take;

  assign s_axis_tready = credit_used < CREDIT_W'(FIFO_DEPTH);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_take      = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit_used <= '0;
    end else begin
      credit_used <= credit_used + CREDIT_W'(in_take) - CREDIT_W'(out_take);
    end
  end

  // Pipeline valid bits.
  logic v1, v2, v3, v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Input register.
  logic signed [DELTA_W-1:0] dx1, dy1;
  logic                      bad1;

  always_ff @(posedge clk) begin
    dx1  <= $signed(s_axis_tdata[DELTA_W-1:0]);
    dy1  <= $signed(s_axis_tdata[2*DELTA_W-1:DELTA_W]);
    bad1 <= s_axis_tuser;
  end

  // Scale the deltas by the sensitivity.
  logic signed [PROD_W-1:0] prod_x2, prod_y2;
  logic                     bad2;

  always_ff @(posedge clk) begin
    prod_x2 <= dx1 * $signed({1'b0, sensitivity});
    prod_y2 <= dy1 * $signed({1'b0, sensitivity});
    bad2    <= bad1;
  end

  // Accumulate yaw with wrap and pitch with clamp.
  logic [ACC_BITS-1:0]       yaw_acc, yaw_acc_next;
  logic signed [PACC_W-1:0]  pitch_acc, pitch_acc_next;
  logic signed [YEXT_W-1:0]  prod_x_ext;
  logic signed [PSUM_W-1:0]  pitch_sum;
  logic signed [PSUM_W-1:0]  pitch_lim;

  always_comb begin
    prod_x_ext     = YEXT_W'(prod_x2);
    pitch_lim      = $signed(PSUM_W'(max_pitch) << FRACTION_BITS);
    pitch_sum      = PSUM_W'(pitch_acc) - PSUM_W'(prod_y2);
    yaw_acc_next   = yaw_acc;
    pitch_acc_next = pitch_acc;
    if (v2 && !bad2) begin
      yaw_acc_next = yaw_acc - prod_x_ext[ACC_BITS-1:0];
      if (pitch_sum > pitch_lim) begin
        pitch_acc_next = PACC_W'(pitch_lim);
      end else if (pitch_sum < -pitch_lim) begin
        pitch_acc_next = PACC_W'(-pitch_lim);
      end else begin
        pitch_acc_next = PACC_W'(pitch_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_acc   <= '0;
      pitch_acc <= '0;
    end else begin
      yaw_acc   <= yaw_acc_next;
      pitch_acc <= pitch_acc_next;
    end
  end

  // Integer angles and their table phases.
  logic signed [ANGLE_BITS-1:0] yaw_int;
  logic signed [PITCH_W-1:0]    pitch_int;
  logic [ANGLE_BITS-1:0]        pitch_wrap;
  logic [PHASE_BITS-1:0]        yaw_phase, pitch_phase;

  assign yaw_int    = $signed(yaw_acc[ACC_BITS-1 -: ANGLE_BITS]);
  assign pitch_int  = PITCH_W'(pitch_acc >>> FRACTION_BITS);
  assign pitch_wrap = ANGLE_BITS'(pitch_int);

  generate
    if (ANGLE_BITS > PHASE_BITS) begin : g_round_phase
      localparam int SH = ANGLE_BITS - PHASE_BITS;
      localparam logic [ANGLE_BITS-1:0] RND = ANGLE_BITS'(1) << (SH - 1);
      logic [ANGLE_BITS-1:0] yaw_rnd, pitch_rnd;
      assign yaw_rnd     = yaw_acc[ACC_BITS-1 -: ANGLE_BITS] + RND;
      assign pitch_rnd   = pitch_wrap + RND;
      assign yaw_phase   = yaw_rnd[ANGLE_BITS-1 -: PHASE_BITS];
      assign pitch_phase = pitch_rnd[ANGLE_BITS-1 -: PHASE_BITS];
    end else begin : g_widen_phase
      assign yaw_phase   = PHASE_BITS'(yaw_acc[ACC_BITS-1 -: ANGLE_BITS])
                           << (PHASE_BITS - ANGLE_BITS);
      assign pitch_phase = PHASE_BITS'(pitch_wrap) << (PHASE_BITS - ANGLE_BITS);
    end
  endgenerate

  // Quarter-wave tables, one per angle, each read at r and at N - r.
  logic [TAB_W-1:0] yaw_rom   [TAB_N+1];
  logic [TAB_W-1:0] pitch_rom [TAB_N+1];

  generate
    for (genvar g = 0; g <= TAB_N; g++) begin : g_rom
      localparam logic [TAB_W-1:0] ENTRY = sine_entry(longint'(g), SINE_TABLE_BITS);
      assign yaw_rom[g]   = ENTRY;
      assign pitch_rom[g] = ENTRY;
    end
  endgenerate

  logic [ADDR_W-1:0] yaw_lo_addr, yaw_hi_addr, pitch_lo_addr, pitch_hi_addr;

  assign yaw_lo_addr   = {1'b0, yaw_phase[SINE_TABLE_BITS-1:0]};
  assign yaw_hi_addr   = ADDR_W'(TAB_N) - yaw_lo_addr;
  assign pitch_lo_addr = {1'b0, pitch_phase[SINE_TABLE_BITS-1:0]};
  assign pitch_hi_addr = ADDR_W'(TAB_N) - pitch_lo_addr;

  logic [TAB_W-1:0]   yaw_lo4, yaw_hi4, pitch_lo4, pitch_hi4;
  logic [1:0]         yaw_q4, pitch_q4;
  logic [YAW_W-1:0]   yaw_out4;
  logic [PITCH_W-1:0] pitch_out4;

  always_ff @(posedge clk) begin
    yaw_lo4    <= yaw_rom[yaw_lo_addr];
    yaw_hi4    <= yaw_rom[yaw_hi_addr];
    pitch_lo4  <= pitch_rom[pitch_lo_addr];
    pitch_hi4  <= pitch_rom[pitch_hi_addr];
    yaw_q4     <= yaw_phase[PHASE_BITS-1 -: 2];
    pitch_q4   <= pitch_phase[PHASE_BITS-1 -: 2];
    yaw_out4   <= YAW_W'(yaw_int);
    pitch_out4 <= pitch_int;
  end

  // Fold the quadrant back in; cosine sits one quadrant ahead of sine.
  logic [1:0]              yaw_qc, pitch_qc;
  logic [TAB_W-1:0]        sy_mag, cy_mag, sp_mag, cp_mag;
  logic signed [DIR_W-1:0] sy, cy, sp, cp;

  always_comb begin
    yaw_qc   = yaw_q4 + 2'd1;
    pitch_qc = pitch_q4 + 2'd1;
    sy_mag   = yaw_q4[0]   ? yaw_hi4   : yaw_lo4;
    cy_mag   = yaw_qc[0]   ? yaw_hi4   : yaw_lo4;
    sp_mag   = pitch_q4[0] ? pitch_hi4 : pitch_lo4;
    cp_mag   = pitch_qc[0] ? pitch_hi4 : pitch_lo4;
    sy = yaw_q4[1]   ? -$signed({1'b0, sy_mag}) : $signed({1'b0, sy_mag});
    cy = yaw_qc[1]   ? -$signed({1'b0, cy_mag}) : $signed({1'b0, cy_mag});
    sp = pitch_q4[1] ? -$signed({1'b0, sp_mag}) : $signed({1'b0, sp_mag});
    cp = pitch_qc[1] ? -$signed({1'b0, cp_mag}) : $signed({1'b0, cp_mag});
  end

  logic signed [2*DIR_W-1:0] prod_xs5, prod_zs5;
  logic signed [DIR_W-1:0]   sp5;
  logic [YAW_W-1:0]          yaw_out5;
  logic [PITCH_W-1:0]        pitch_out5;

  always_ff @(posedge clk) begin
    prod_xs5   <= cp * sy;
    prod_zs5   <= cp * cy;
    sp5        <= sp;
    yaw_out5   <= yaw_out4;
    pitch_out5 <= pitch_out4;
  end

  // Round the Q2.30 products half up and negate.
  logic signed [2*DIR_W-1:0] rnd_x, rnd_z;
  logic [DIR_W-1:0]          dir_x, dir_z;

  always_comb begin
    rnd_x = (prod_xs5 + 32'sd16384) >>> 15;
    rnd_z = (prod_zs5 + 32'sd16384) >>> 15;
    dir_x = DIR_W'(-rnd_x);
    dir_z = DIR_W'(-rnd_z);
  end

  // Output queue.
  logic [OUT_DATA_W-1:0] fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CREDIT_W-1:0]   fifo_count;

  always_ff @(posedge clk) begin
    if (v5) begin
      fifo_mem[wr_ptr] <= {1'b0, dir_z, sp5, dir_x, pitch_out5, yaw_out5};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (v5) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (out_take) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      fifo_count <= fifo_count + CREDIT_W'(v5) - CREDIT_W'(out_take);
    end
  end

  assign m_axis_tvalid = fifo_count != '0;
  assign m_axis_tdata  = fifo_mem[rd_ptr];

`ifndef SYNTH
  // Queued words are always covered by credits.
  assert property (@(posedge clk) disable iff (rst)
    (fifo_count <= credit_used) && (credit_used <= CREDIT_W'(FIFO_DEPTH)))
    else $error("credit count does not cover the output queue");

  // A word leaving the pipeline always finds room in the queue.
  assert property (@(posedge clk) disable iff (rst)
    v5 |-> (fifo_count < CREDIT_W'(FIFO_DEPTH)))
    else $error("output queue overflow");

  // A bad sample leaves both accumulators untouched.
  assert property (@(posedge clk) disable iff (rst)
    (v2 && bad2) |=> ($stable(yaw_acc) && $stable(pitch_acc)))
    else $error("bad sample changed the view state");

  // After a good sample, pitch sits within the clamp limit.
  assert property (@(posedge clk) disable iff (rst)
    (v2 && !bad2) |=> ((PSUM_W'(pitch_acc) <= pitch_lim) &&
                       (PSUM_W'(pitch_acc) >= -pitch_lim)))
    else $error("pitch outside clamp limit");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ypvt_pkg::*;

  localparam int LUT_SIZE = 1024;
  localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam int RUN_PHASES = 8;
  localparam int PHASE_WORDS = 240;

  // One output word, laid out as on m_axis_tdata (yaw in the lowest bits).
  typedef struct packed {
    logic signed [DIR_W-1:0]   dir_z;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [YAW_W-1:0]   yaw;
  } view_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  // One step of the directed part: either a pointer word or a register setting.
  typedef struct {
    row_kind_t kind;
    int        dx;
    int        dy;
    bit        bad;
    int        sens;
    int        lim;
    bit        typed;
    view_t     want;
  } plan_row_t;

  // Straight ahead after reset: looking down the negative z axis.
  localparam view_t RESET_VIEW = '{dir_z: -16'sd32766, default: '0};

  logic                    clk;
  logic                    rst;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata;   // delta_x [15:0], delta_y [31:16]
  logic                    s_axis_tuser;   // delta_bad [0]
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;   // yaw, pitch, dir_x, dir_y, dir_z, zero pad
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_ADDR_W-1:0]   paddr;
  logic [APB_DATA_W-1:0]   pwdata;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  // Tracker state as the testbench sees it.
  logic [23:0]        yaw_phase;
  longint             pitch_fix;
  logic [SENS_W-1:0]  sens_now;
  logic [LIMIT_W-1:0] limit_now;
  int                 sine_lut [0:LUT_SIZE];

  view_t views_due [$];
  int    fail_count = 0;
  bit    tx_idling = 1'b1;
  bit    rx_idling = 1'b1;
  plan_row_t plan [$];

  yaw_pitch_view_tracker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Quarter-wave sine table from a fifteenth-order fixed-point Taylor series.
  initial begin
    longint x;
    longint t;
    longint sum;
    longint q;
    int     i;
    int     k;
    for (i = 0; i <= LUT_SIZE; i++) begin
      x   = (QUARTER_TURN_Q30 * i) >>> 10;
      t   = x;
      sum = x;
      for (k = 1; k <= 7; k++) begin
        t = (t * x) >>> 30;
        t = (t * x) >>> 30;
        t = t / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - t;
        end else begin
          sum = sum + t;
        end
      end
      if (sum < 0) sum = 0;
      q = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
      if (q > 32767) q = 32767;
      sine_lut[i] = int'(q);
    end
  end

  // Sine of a 16-bit binary angle, rounded onto a 12-bit phase that wraps.
  function automatic int sine_at(logic [15:0] ang);
    logic [16:0] rounded;
    logic [11:0] phase;
    int          v;
    rounded = {1'b0, ang} + 17'd8;
    phase   = rounded[15:4];
    v = phase[10] ? sine_lut[LUT_SIZE - int'(phase[9:0])] : sine_lut[phase[9:0]];
    return phase[11] ? -v : v;
  endfunction

  // Applies one pointer word to the tracker state and returns the view it shows.
  function automatic view_t advance_view(logic signed [15:0] dx, logic signed [15:0] dy,
                                         logic bad);
    longint      lim;
    longint      pitch_i;
    longint      sy;
    longint      cy;
    longint      sp;
    longint      cp;
    logic [15:0] yaw_i;
    view_t       v;
    if (!bad) begin
      lim       = longint'(limit_now) <<< 8;
      yaw_phase = yaw_phase - 24'(longint'(dx) * longint'(sens_now));
      pitch_fix = pitch_fix - longint'(dy) * longint'(sens_now);
      if (pitch_fix > lim) pitch_fix = lim;
      if (pitch_fix < -lim) pitch_fix = -lim;
    end
    yaw_i   = yaw_phase[23:8];
    pitch_i = pitch_fix >>> 8;
    sy = sine_at(yaw_i);
    cy = sine_at(yaw_i + QUARTER_TURN);
    sp = sine_at(16'(pitch_i));
    cp = sine_at(16'(pitch_i) + QUARTER_TURN);
    v.yaw   = yaw_i;
    v.pitch = 15'(pitch_i);
    v.dir_x = 16'(-((cp * sy + 64'sd16384) >>> 15));
    v.dir_y = 16'(sp);
    v.dir_z = 16'(-((cp * cy + 64'sd16384) >>> 15));
    return v;
  endfunction

  function automatic void compare_field(string name, logic signed [15:0] want,
                                        logic signed [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Mostly small motion, with full-range words and extremes mixed in.
  function automatic logic signed [15:0] pick_delta();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: return 16'($urandom_range(0, 128)) - 16'sd64;
    endcase
  endfunction

  // Offers one pointer word, with an occasional gap ahead of it.
  task automatic push_delta(logic signed [15:0] dx, logic signed [15:0] dy, logic bad,
                            bit typed, view_t want);
    view_t pred;
    if (tx_idling && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dy, dx};
    s_axis_tuser  <= bad;
    do @(posedge clk); while (!s_axis_tready);
    pred = advance_view(dx, dy, bad);
    views_due.push_back(typed ? want : pred);
  endtask

  // Holds the input stream until every expected word has come out.
  task automatic drain_views();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (views_due.size() != 0);
  endtask

  // Writes both registers, then reads them back.
  task automatic program_view(logic [SENS_W-1:0] sens, logic [LIMIT_W-1:0] lim);
    logic [APB_DATA_W-1:0] value;
    logic                  reg_idx;
    int                    k;
    for (k = 0; k < 4; k++) begin
      reg_idx = (k % 2 == 1) ? REG_MAX_PITCH : REG_SENSITIVITY;
      value   = (k % 2 == 1) ? APB_DATA_W'(lim) : APB_DATA_W'(sens);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (k < 2);
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (k >= 2 && prdata !== value) begin
        $error("prdata: expected %0d actual %0d", value, prdata);
        fail_count++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sens_now  = sens;
    limit_now = lim;
  endtask

  // Output side: random back-pressure bursts while idling is on.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      if (rx_idling && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Each accepted output word is checked against the oldest expected view.
  always @(posedge clk) begin
    view_t got;
    view_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = view_t'(m_axis_tdata[78:0]);
      compare_field("pad", 16'sd0, {15'd0, m_axis_tdata[79]});
      if (views_due.size() == 0) begin
        $error("unexpected output word: yaw %0d pitch %0d", got.yaw, got.pitch);
        fail_count++;
      end else begin
        want = views_due.pop_front();
        compare_field("yaw_angle", want.yaw, got.yaw);
        compare_field("pitch_angle", want.pitch, got.pitch);
        compare_field("dir_x", want.dir_x, got.dir_x);
        compare_field("dir_y", want.dir_y, got.dir_y);
        compare_field("dir_z", want.dir_z, got.dir_z);
      end
    end
  end

  initial begin
    plan_row_t         row;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [SENS_W-1:0]  sens;
    logic [LIMIT_W-1:0] lim;
    int                 p;
    int                 n;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    yaw_phase     = '0;
    pitch_fix     = 0;
    sens_now      = 16'd256;
    limit_now     = 14'd16000;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset view, bad sample, extremes, yaw reaching a half turn.
    plan.push_back('{ROW_ITEM, 32767, 32767, 1, 0, 0, 1, RESET_VIEW});
    plan.push_back('{ROW_ITEM, 0, 0, 0, 0, 0, 1, RESET_VIEW});
    plan.push_back('{ROW_ITEM, 1, 0, 0, 0, 0, 0, '0});
    plan.push_back('{ROW_ITEM, -32768, -32768, 0, 0, 0, 0, '0});
    plan.push_back('{ROW_ITEM, 32767, 32767, 0, 0, 0, 0, '0});
    plan.push_back('{ROW_ITEM, -32768, 0, 0, 0, 0, 0, '0});
    plan.push_back('{ROW_ITEM, -1, -1, 1, 0, 0, 0, '0});
    // A lowered limit only bites on the next good sample.
    plan.push_back('{ROW_CFG, 0, 0, 0, 256, 100, 0, '0});
    plan.push_back('{ROW_ITEM, 0, 0, 1, 0, 0, 0, '0});
    plan.push_back('{ROW_ITEM, 0, 0, 0, 0, 0, 0, '0});
    // Zero sensitivity freezes the view.
    plan.push_back('{ROW_CFG, 0, 0, 0, 0, 100, 0, '0});
    plan.push_back('{ROW_ITEM, 12345, -12345, 0, 0, 0, 0, '0});
    // Largest sensitivity and limit.
    plan.push_back('{ROW_CFG, 0, 0, 0, 65535, 16383, 0, '0});
    plan.push_back('{ROW_ITEM, 1, -1, 0, 0, 0, 0, '0});
    plan.push_back('{ROW_ITEM, -32768, -32768, 0, 0, 0, 0, '0});
    plan.push_back('{ROW_ITEM, 32767, 32767, 0, 0, 0, 0, '0});
    // Zero limit pins pitch at level.
    plan.push_back('{ROW_CFG, 0, 0, 0, 1, 0, 0, '0});
    plan.push_back('{ROW_ITEM, 3, -5, 0, 0, 0, 0, '0});
    // Fractional steps: pitch just below zero floors to -1.
    plan.push_back('{ROW_CFG, 0, 0, 0, 1, 16383, 0, '0});
    plan.push_back('{ROW_ITEM, -1, 1, 0, 0, 0, 0, '0});
    plan.push_back('{ROW_ITEM, 128, -1, 0, 0, 0, 0, '0});
    plan.push_back('{ROW_ITEM, 21845, -21846, 0, 0, 0, 0, '0});
    plan.push_back('{ROW_ITEM, -21846, 21845, 1, 0, 0, 0, '0});

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        drain_views();
        program_view(SENS_W'(row.sens), LIMIT_W'(row.lim));
      end else begin
        push_delta(16'(row.dx), 16'(row.dy), row.bad, row.typed, row.want);
      end
    end

    // Random phases, each under its own register setting; the last runs flat out.
    for (p = 0; p < RUN_PHASES; p++) begin
      case (p)
        1: begin
          sens = 16'd65535;
          lim  = 14'd16383;
        end
        2: begin
          sens = 16'd0;
          lim  = 14'd0;
        end
        3: begin
          sens = 16'd256;
          lim  = 14'd16000;
        end
        default: begin
          sens = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(1, 1024));
          lim  = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 200))
                                             : 14'($urandom_range(0, 16383));
        end
      endcase
      drain_views();
      program_view(sens, lim);
      tx_idling = (p != RUN_PHASES - 1);
      rx_idling = (p != RUN_PHASES - 1);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (n == PHASE_WORDS / 2 || $urandom_range(0, 149) == 0) begin
          drain_views();
        end
        dx = pick_delta();
        dy = pick_delta();
        push_delta(dx, dy, $urandom_range(0, 9) == 0, 1'b0, '0);
      end
    end

    // Let the last words out, then allow for the pipeline depth.
    drain_views();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
